### rtl/feps_pkg.sv
// ----------------------------------------------------------------------------
// feps_pkg
// Shared types and constants for the flash erase/program sequencer.
// ----------------------------------------------------------------------------
package feps_pkg;

  localparam int PAGE_BYTES = 128;
  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 11;
  localparam int STAT_W   = 18;
  localparam int ERR_W    = 7;
  localparam int RES_W    = 2;
  localparam int ACT_W    = 3;
  localparam int REQ_W    = 2;
  localparam int TICK_W   = 16;
  localparam int WAIT_W   = TICK_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 16;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 112;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int NSLOT   = 8;
  localparam int SLOT_W  = $clog2(NSLOT);

  localparam logic [ADDR_W-1:0] ALL_ONES   = '1;
  localparam logic [DATA_W-1:0] CTL_PROG   = 32'h0000_0008;
  localparam logic [DATA_W-1:0] CTL_ERASE  = 32'h0000_0200;
  localparam logic [DATA_W-1:0] EOP_MASK   = 32'h0000_0002;
  localparam logic [STAT_W-1:0] ERR_MASK   = 18'h32F00;
  localparam logic [ADDR_W-1:0] PAGE_ALIGN = ~(ADDR_W'(PAGE_BYTES) - ADDR_W'(1));

  // request kinds
  localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PROG   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STATUS = 2'd2;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

  // bus actions
  localparam logic [ACT_W-1:0] ACT_SET   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CLR   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SCLR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DONE  = 3'd4;

  // completion status
  localparam logic [RES_W-1:0] RS_OK      = 2'd0;
  localparam logic [RES_W-1:0] RS_ERROR   = 2'd1;
  localparam logic [RES_W-1:0] RS_BUSY    = 2'd2;
  localparam logic [RES_W-1:0] RS_TIMEOUT = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_TIMEOUT = 1'b1;
  localparam logic [TICK_W-1:0]    TIMEOUT_RST    = 16'd50000;

  // result slots, emitted lowest first
  localparam logic [SLOT_W-1:0] SLOT_EOP   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_ECLR  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_CLRP  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_CLRE  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_SETE  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_SETP  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_WRITE = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_DONE  = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PRE  = 3'b010,
    PH_OP   = 3'b100
  } phase_t;

  // one run of results, as handed from front to back
  typedef struct packed {
    logic [NSLOT-1:0]  slots;
    logic [STAT_W-1:0] clr_mask;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [RES_W-1:0]  status;
    logic [ERR_W-1:0]  err_old;
    logic [ERR_W-1:0]  err_new;
    logic [ADDR_W-1:0] fail;
  } run_t;

endpackage

### rtl/feps_front.sv
// ----------------------------------------------------------------------------
// feps_front
// Accepts commands, status samples and ticks; tracks sequencing state and
// emits one run descriptor per item that produces results.
// ----------------------------------------------------------------------------
module feps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [feps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [feps_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           acc,
  input  logic [feps_pkg::REQ_W-1:0]     req_type,
  input  logic [feps_pkg::ADDR_W-1:0]    address,
  input  logic [feps_pkg::CNT_W-1:0]     page_count,
  input  logic [feps_pkg::DATA_W-1:0]    write_data,
  input  logic [feps_pkg::STAT_W-1:0]    status_word,
  output logic                           push,
  output feps_pkg::run_t                 run
);
  import feps_pkg::*;

  logic [TICK_W-1:0] timeout_r;
  logic              no_to_r;
  phase_t            phase_r, phase_nxt;
  logic              erase_r, erase_nxt;
  logic [ERR_W-1:0]  sticky_r, sticky_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [WAIT_W-1:0] wc_r, wc_nxt;
  logic [ADDR_W-1:0] fail_r, fail_nxt;
  logic [ADDR_W-1:0] paddr_r, paddr_nxt;
  logic [DATA_W-1:0] pword_r, pword_nxt;

  logic              active;
  logic              do_timeout;
  logic [WAIT_W-1:0] wc_inc;
  logic [STAT_W-1:0] emask;
  logic [ERR_W-1:0]  codes;
  logic              bad;
  logic [ADDR_W-1:0] cnt_clip;
  logic [ADDR_W-1:0] cursor_inc;

  assign active     = (phase_r != PH_IDLE);
  assign wc_inc     = (wc_r == '1) ? wc_r : wc_r + WAIT_W'(1);
  assign emask      = status_word & ERR_MASK;
  assign codes      = {status_word[16], status_word[17], status_word[13],
                       status_word[10], status_word[11], status_word[8],
                       status_word[9]};
  assign bad        = |emask;
  assign cnt_clip   = (ADDR_W'(page_count) > ADDR_W'(MAX_PAGES)) ?
                      ADDR_W'(MAX_PAGES) : ADDR_W'(page_count);
  assign cursor_inc = cursor_r + ADDR_W'(PAGE_BYTES);

  always_comb begin
    phase_nxt  = phase_r;
    erase_nxt  = erase_r;
    sticky_nxt = sticky_r;
    cursor_nxt = cursor_r;
    end_nxt    = end_r;
    wc_nxt     = wc_r;
    fail_nxt   = fail_r;
    paddr_nxt  = paddr_r;
    pword_nxt  = pword_r;
    do_timeout = 1'b0;
    run          = '0;
    run.err_old  = sticky_r;
    run.err_new  = sticky_r;
    run.fail     = fail_r;

    if (acc) begin
      case (req_type) inside
        REQ_ERASE, REQ_PROG: begin
          if (active) begin
            run.slots[SLOT_DONE] = 1'b1;
            run.status           = RS_BUSY;
          end else begin
            erase_nxt = (req_type == REQ_ERASE);
            fail_nxt  = ALL_ONES;
            phase_nxt = PH_PRE;
            wc_nxt    = '0;
            if (req_type == REQ_ERASE) begin
              cursor_nxt = address;
              end_nxt    = address + (cnt_clip << PAGE_SHIFT);
            end else begin
              paddr_nxt = address;
              pword_nxt = write_data;
            end
          end
        end
        REQ_TICK: begin
          if (active && !no_to_r) begin
            wc_nxt = wc_inc;
            if (wc_inc > WAIT_W'(timeout_r)) do_timeout = 1'b1;
          end
        end
        default: begin
          if (active) begin
            if (status_word[0]) begin
              if (!no_to_r && timeout_r == '0) do_timeout = 1'b1;
            end else begin
              run.slots[SLOT_EOP]  = status_word[1];
              run.slots[SLOT_ECLR] = bad;
              run.clr_mask         = emask;
              run.err_new          = sticky_r | codes;
              sticky_nxt           = sticky_r | codes;
              unique case (phase_r)
                PH_PRE: begin
                  if (bad) begin
                    run.slots[SLOT_DONE] = 1'b1;
                    run.status           = RS_ERROR;
                    phase_nxt            = PH_IDLE;
                  end else if (erase_r) begin
                    if (cursor_r < end_r) begin
                      run.slots[SLOT_SETE]  = 1'b1;
                      run.slots[SLOT_SETP]  = 1'b1;
                      run.slots[SLOT_WRITE] = 1'b1;
                      run.waddr             = cursor_r & PAGE_ALIGN;
                      sticky_nxt            = '0;
                      phase_nxt             = PH_OP;
                      wc_nxt                = '0;
                    end else begin
                      run.slots[SLOT_DONE] = 1'b1;
                      run.status           = RS_OK;
                      phase_nxt            = PH_IDLE;
                    end
                  end else begin
                    run.slots[SLOT_WRITE] = 1'b1;
                    run.waddr             = paddr_r;
                    run.wdata             = pword_r;
                    sticky_nxt            = '0;
                    phase_nxt             = PH_OP;
                    wc_nxt                = '0;
                  end
                end
                PH_OP: begin
                  if (erase_r) begin
                    run.slots[SLOT_CLRP] = 1'b1;
                    run.slots[SLOT_CLRE] = 1'b1;
                    if (bad) begin
                      fail_nxt             = cursor_r;
                      run.fail             = cursor_r;
                      run.slots[SLOT_DONE] = 1'b1;
                      run.status           = RS_ERROR;
                      phase_nxt            = PH_IDLE;
                    end else begin
                      cursor_nxt = cursor_inc;
                      if (cursor_inc < end_r) begin
                        run.slots[SLOT_SETE]  = 1'b1;
                        run.slots[SLOT_SETP]  = 1'b1;
                        run.slots[SLOT_WRITE] = 1'b1;
                        run.waddr             = cursor_inc & PAGE_ALIGN;
                        sticky_nxt            = '0;
                        wc_nxt                = '0;
                      end else begin
                        run.slots[SLOT_DONE] = 1'b1;
                        run.status           = RS_OK;
                        phase_nxt            = PH_IDLE;
                      end
                    end
                  end else begin
                    run.slots[SLOT_DONE] = 1'b1;
                    run.status           = bad ? RS_ERROR : RS_OK;
                    phase_nxt            = PH_IDLE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      endcase

      if (do_timeout) begin
        if (phase_r == PH_OP && erase_r) begin
          run.slots[SLOT_CLRP] = 1'b1;
          run.slots[SLOT_CLRE] = 1'b1;
          fail_nxt             = cursor_r;
          run.fail             = cursor_r;
        end
        run.slots[SLOT_DONE] = 1'b1;
        run.status           = RS_TIMEOUT;
        phase_nxt            = PH_IDLE;
      end
    end
  end

  assign push = |run.slots;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      no_to_r   <= 1'b0;
      phase_r   <= PH_IDLE;
      erase_r   <= 1'b0;
      sticky_r  <= '0;
      cursor_r  <= '0;
      end_r     <= '0;
      wc_r      <= '0;
      fail_r    <= ALL_ONES;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_r <= cfg_wdata;
        if (cfg_index == CFG_NO_TIMEOUT) no_to_r <= cfg_wdata[0];
      end
      phase_r  <= phase_nxt;
      erase_r  <= erase_nxt;
      sticky_r <= sticky_nxt;
      cursor_r <= cursor_nxt;
      end_r    <= end_nxt;
      wc_r     <= wc_nxt;
      fail_r   <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    paddr_r <= paddr_nxt;
    pword_r <= pword_nxt;
  end

endmodule

### rtl/feps_queue.sv
// ----------------------------------------------------------------------------
// feps_queue
// Small FIFO of run descriptors between front and back.
// ----------------------------------------------------------------------------
module feps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  feps_pkg::run_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output feps_pkg::run_t head
);
  import feps_pkg::*;

  run_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    if (!push && pop) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop) rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

### rtl/feps_back.sv
// ----------------------------------------------------------------------------
// feps_back
// Expands run descriptors into bus actions, one per cycle while the output is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
module feps_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        empty,
  input  feps_pkg::run_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [feps_pkg::ACT_W-1:0]  action,
  output logic [feps_pkg::ADDR_W-1:0] bus_address,
  output logic [feps_pkg::DATA_W-1:0] bus_data,
  output logic [feps_pkg::RES_W-1:0]  result_status,
  output logic [feps_pkg::ERR_W-1:0]  error_code,
  output logic [feps_pkg::ADDR_W-1:0] failing_address,
  output logic                        last
);
  import feps_pkg::*;

  logic [NSLOT-1:0]  rem_r;
  logic              started_r;
  logic              valid_r;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [RES_W-1:0]  rs_r, rs_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [ADDR_W-1:0] fail_r, fail_nxt;
  logic              last_r;

  logic              adv;
  logic [NSLOT-1:0]  mask, rem_nxt;
  logic [SLOT_W-1:0] idx;

  assign adv  = !empty && (!valid_r || out_ready);
  assign mask = started_r ? rem_r : head.slots;

  always_comb begin
    idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask[i]) idx = SLOT_W'(i);
    end
  end

  always_comb begin
    rem_nxt      = mask;
    rem_nxt[idx] = 1'b0;
  end

  assign pop = adv && (rem_nxt == '0);

  always_comb begin
    act_nxt  = ACT_DONE;
    addr_nxt = '0;
    data_nxt = '0;
    rs_nxt   = '0;
    err_nxt  = head.err_new;
    fail_nxt = ALL_ONES;
    unique case (idx)
      SLOT_EOP: begin
        act_nxt  = ACT_SCLR;
        data_nxt = EOP_MASK;
        err_nxt  = head.err_old;
      end
      SLOT_ECLR: begin
        act_nxt  = ACT_SCLR;
        data_nxt = DATA_W'(head.clr_mask);
      end
      SLOT_CLRP: begin
        act_nxt  = ACT_CLR;
        data_nxt = CTL_PROG;
      end
      SLOT_CLRE: begin
        act_nxt  = ACT_CLR;
        data_nxt = CTL_ERASE;
      end
      SLOT_SETE: begin
        act_nxt  = ACT_SET;
        data_nxt = CTL_ERASE;
        err_nxt  = '0;
      end
      SLOT_SETP: begin
        act_nxt  = ACT_SET;
        data_nxt = CTL_PROG;
        err_nxt  = '0;
      end
      SLOT_WRITE: begin
        act_nxt  = ACT_WRITE;
        addr_nxt = head.waddr;
        data_nxt = head.wdata;
        err_nxt  = '0;
      end
      SLOT_DONE: begin
        act_nxt  = ACT_DONE;
        rs_nxt   = head.status;
        fail_nxt = head.fail;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      started_r <= 1'b0;
      rem_r     <= '0;
    end else begin
      if (adv) begin
        valid_r   <= 1'b1;
        started_r <= (rem_nxt != '0);
        rem_r     <= rem_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_r  <= act_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      rs_r   <= rs_nxt;
      err_r  <= err_nxt;
      fail_r <= fail_nxt;
      last_r <= (rem_nxt == '0);
    end
  end

  assign out_valid       = valid_r;
  assign action          = act_r;
  assign bus_address     = addr_r;
  assign bus_data        = data_r;
  assign result_status   = rs_r;
  assign error_code      = err_r;
  assign failing_address = fail_r;
  assign last            = last_r;

endmodule

### rtl/flash_erase_program_sequencer.sv
// ----------------------------------------------------------------------------
// flash_erase_program_sequencer
// Sequences page erase and word program on a flash controller from commands,
// status samples and ticks.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | tuser              | tdata
//  in_     | in  | in_tvalid / in_tready  | req_type           | address, page_count,
//          |     |                        |                    | write_data, status_word
//  out_    | out | out_tvalid/out_tready  | action             | bus_address, bus_data,
//          |     |                        |                    | result_status, error_code,
//          |     |                        |                    | failing_address (+tlast)
//  cfg_    | in  | cfg_we                 | -                  | cfg_index, cfg_wdata
//
//  Front state updates in the cycle a transaction is accepted; one item per
//  cycle while the 4-entry run queue has room.
//  Back emits one result per cycle from the queue head unless stalled; an item's run is
//  0 to 6 results, so sustained rate is set by result count per item.
//  Synchronous active-low reset; no clearing pass.
//  Output stall fills the queue, then in_tready drops.
// ----------------------------------------------------------------------------
module flash_erase_program_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [feps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [feps_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // address[31:0], page_count[42:32], write_data[74:43], status_word[92:75]
  input  logic [feps_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type[1:0]
  input  logic [feps_pkg::REQ_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // bus_address[31:0], bus_data[63:32], result_status[65:64],
  // error_code[72:66], failing_address[104:73]
  output logic [feps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // action[2:0]
  output logic [feps_pkg::ACT_W-1:0]          out_tuser,
  output logic                                out_tlast
);
  import feps_pkg::*;

  logic              acc;
  logic              push, pop, full, empty;
  run_t              run, head;
  logic [ADDR_W-1:0] bus_address, failing_address;
  logic [DATA_W-1:0] bus_data;
  logic [RES_W-1:0]  result_status;
  logic [ERR_W-1:0]  error_code;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  feps_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .req_type    (in_tuser),
    .address     (in_tdata[31:0]),
    .page_count  (in_tdata[42:32]),
    .write_data  (in_tdata[74:43]),
    .status_word (in_tdata[92:75]),
    .push        (push),
    .run         (run)
  );

  feps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (run),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  feps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .action          (out_tuser),
    .bus_address     (bus_address),
    .bus_data        (bus_data),
    .result_status   (result_status),
    .error_code      (error_code),
    .failing_address (failing_address),
    .last            (out_tlast)
  );

  assign out_tdata = {7'b0, failing_address, error_code, result_status, bus_data,
                      bus_address};

endmodule

### rtl/fepschk.sv
// ----------------------------------------------------------------------------
// fepschk
// Port-level checks on the result stream of the sequencer.
// ----------------------------------------------------------------------------
module fepschk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [feps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [feps_pkg::ACT_W-1:0]       out_tuser,
  input logic                             out_tlast
);
  import feps_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_DONE |-> out_tlast)
    else $error("done is not last of its run");

  a_addr_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_WRITE |-> out_tdata[31:0] == '0)
    else $error("bus address outside array write");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_DONE |-> out_tdata[65:64] == RS_OK)
    else $error("result status outside done");

  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_DONE |-> out_tdata[104:73] == ALL_ONES)
    else $error("failing address set before done");

endmodule

bind flash_erase_program_sequencer fepschk u_fepschk (.*);

### tb/flash_erase_program_sequencer_checker.sv
// ----------------------------------------------------------------------------
// flash_erase_program_sequencer_checker
// Watches the register port and both stream channels of the sequencer. It
// keeps its own copy of the sequencer state and registers, computes the bus
// actions that each accepted transaction should cause, and compares every
// accepted result with the oldest action still due. It hands the mismatch
// count and the number of actions still due to the bench top.
// ----------------------------------------------------------------------------
module flash_erase_program_sequencer_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [feps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [feps_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // address[31:0], page_count[42:32], write_data[74:43], status_word[92:75]
  input  logic [feps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [feps_pkg::REQ_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // bus_address[31:0], bus_data[63:32], result_status[65:64],
  // error_code[72:66], failing_address[104:73]
  input  logic [feps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // action[2:0]
  input  logic [feps_pkg::ACT_W-1:0]       out_tuser,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import feps_pkg::*;

  // status register bit positions
  localparam int ST_BUSY    = 0;
  localparam int ST_EOP     = 1;
  localparam int ST_WRP     = 8;
  localparam int ST_PGA     = 9;
  localparam int ST_SIZE    = 10;
  localparam int ST_OPTV    = 11;
  localparam int ST_RD      = 13;
  localparam int ST_NOTZERO = 16;
  localparam int ST_ABORT   = 17;

  // sticky error code bits
  localparam logic [ERR_W-1:0] ERR_PGA     = 7'h01;
  localparam logic [ERR_W-1:0] ERR_WRP     = 7'h02;
  localparam logic [ERR_W-1:0] ERR_OPTV    = 7'h04;
  localparam logic [ERR_W-1:0] ERR_SIZE    = 7'h08;
  localparam logic [ERR_W-1:0] ERR_RD      = 7'h10;
  localparam logic [ERR_W-1:0] ERR_ABORT   = 7'h20;
  localparam logic [ERR_W-1:0] ERR_NOTZERO = 7'h40;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
    logic [RES_W-1:0]  result_status;
    logic [ERR_W-1:0]  error_code;
    logic [ADDR_W-1:0] failing_address;
    logic              last;
  } bus_action_t;

  bus_action_t due_actions[$];
  bus_action_t run_actions[$];

  logic [TICK_W-1:0] cfg_timeout;
  logic              cfg_free_run;

  phase_t            seq_phase;
  logic              active;
  logic              erasing;
  logic [ERR_W-1:0]  sticky;
  logic [ADDR_W-1:0] page_cursor;
  logic [ADDR_W-1:0] erase_end;
  logic [31:0]       wait_count;
  logic [DATA_W-1:0] pending_word;
  logic [ADDR_W-1:0] pending_address;
  logic [ADDR_W-1:0] fail_addr;

  function automatic logic [ERR_W-1:0] err_code_of(int pos);
    case (pos)
      ST_WRP:     return ERR_WRP;
      ST_PGA:     return ERR_PGA;
      ST_SIZE:    return ERR_SIZE;
      ST_OPTV:    return ERR_OPTV;
      ST_RD:      return ERR_RD;
      ST_NOTZERO: return ERR_NOTZERO;
      ST_ABORT:   return ERR_ABORT;
      default:    return '0;
    endcase
  endfunction

  task automatic post(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                      input logic [DATA_W-1:0] data, input logic [RES_W-1:0] status);
    bus_action_t a;
    a.action          = act;
    a.bus_address     = addr;
    a.bus_data        = data;
    a.result_status   = status;
    a.error_code      = sticky;
    a.failing_address = fail_addr;
    a.last            = 1'b0;
    run_actions.push_back(a);
  endtask

  task automatic complete(input logic [RES_W-1:0] status);
    post(ACT_DONE, '0, '0, status);
    seq_phase = PH_IDLE;
    active    = 1'b0;
  endtask

  task automatic open_page();
    sticky = '0;
    post(ACT_SET, '0, CTL_ERASE, RS_OK);
    post(ACT_SET, '0, CTL_PROG, RS_OK);
    post(ACT_WRITE, page_cursor & PAGE_ALIGN, '0, RS_OK);
    seq_phase  = PH_OP;
    wait_count = '0;
  endtask

  task automatic abandon_wait();
    if (seq_phase == PH_OP && erasing) begin
      post(ACT_CLR, '0, CTL_PROG, RS_OK);
      post(ACT_CLR, '0, CTL_ERASE, RS_OK);
      fail_addr = page_cursor;
    end
    complete(RS_TIMEOUT);
  endtask

  // clear end flag, fold error flags into sticky code and clear them
  task automatic fold_flags(input logic [STAT_W-1:0] st, output logic bad);
    logic [STAT_W-1:0] mask;
    mask = '0;
    if (st[ST_EOP]) post(ACT_SCLR, '0, EOP_MASK, RS_OK);
    for (int pos = ST_WRP; pos <= ST_ABORT; pos++) begin
      if (err_code_of(pos) != '0 && st[pos]) begin
        sticky    = sticky | err_code_of(pos);
        mask[pos] = 1'b1;
      end
    end
    bad = (mask != '0);
    if (bad) post(ACT_SCLR, '0, DATA_W'(mask), RS_OK);
  endtask

  task automatic sequence_item(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                               input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] wdata,
                               input logic [STAT_W-1:0] st);
    logic              bad;
    logic [ADDR_W-1:0] pages;
    run_actions.delete();
    if (req == REQ_ERASE || req == REQ_PROG) begin
      if (active) begin
        post(ACT_DONE, '0, '0, RS_BUSY);
      end else begin
        erasing    = (req == REQ_ERASE);
        fail_addr  = ALL_ONES;
        seq_phase  = PH_PRE;
        active     = 1'b1;
        wait_count = '0;
        if (erasing) begin
          pages       = (cnt > MAX_PAGES) ? ADDR_W'(MAX_PAGES) : ADDR_W'(cnt);
          page_cursor = addr;
          erase_end   = addr + pages * ADDR_W'(PAGE_BYTES);
        end else begin
          pending_address = addr;
          pending_word    = wdata;
        end
      end
    end else if (active) begin
      if (req == REQ_TICK) begin
        if (!cfg_free_run) begin
          if (wait_count != '1) wait_count = wait_count + 1;
          if (wait_count > cfg_timeout) abandon_wait();
        end
      end else if (st[ST_BUSY]) begin
        if (!cfg_free_run && cfg_timeout == '0) abandon_wait();
      end else begin
        fold_flags(st, bad);
        if (seq_phase == PH_PRE) begin
          if (bad) begin
            complete(RS_ERROR);
          end else if (erasing) begin
            if (page_cursor < erase_end) open_page();
            else complete(RS_OK);
          end else begin
            sticky = '0;
            post(ACT_WRITE, pending_address, pending_word, RS_OK);
            seq_phase  = PH_OP;
            wait_count = '0;
          end
        end else if (erasing) begin
          post(ACT_CLR, '0, CTL_PROG, RS_OK);
          post(ACT_CLR, '0, CTL_ERASE, RS_OK);
          if (bad) begin
            fail_addr = page_cursor;
            complete(RS_ERROR);
          end else begin
            page_cursor = page_cursor + ADDR_W'(PAGE_BYTES);
            if (page_cursor < erase_end) open_page();
            else complete(RS_OK);
          end
        end else begin
          complete(bad ? RS_ERROR : RS_OK);
        end
      end
    end
    if (run_actions.size() > 0) run_actions[run_actions.size() - 1].last = 1'b1;
    foreach (run_actions[i]) due_actions.push_back(run_actions[i]);
  endtask

  task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bus_action_t want;
    if (!rst_n) begin
      cfg_timeout     = TIMEOUT_RST;
      cfg_free_run    = 1'b0;
      seq_phase       = PH_IDLE;
      active          = 1'b0;
      erasing         = 1'b0;
      sticky          = '0;
      page_cursor     = '0;
      erase_end       = '0;
      wait_count      = '0;
      pending_word    = '0;
      pending_address = '0;
      fail_addr       = ALL_ONES;
      due_actions.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) cfg_timeout = cfg_wdata[TICK_W-1:0];
        else if (cfg_index == CFG_NO_TIMEOUT) cfg_free_run = cfg_wdata[0];
      end
      if (in_tvalid && in_tready)
        sequence_item(in_tuser, in_tdata[31:0], in_tdata[42:32], in_tdata[74:43],
                      in_tdata[92:75]);
      if (out_tvalid && out_tready) begin
        if (due_actions.size() == 0) begin
          $error("unexpected result transaction: action %0d, tdata 0x%0h", out_tuser,
                 out_tdata);
          fail_count++;
        end else begin
          want = due_actions.pop_front();
          check_field("action", ADDR_W'(want.action), ADDR_W'(out_tuser));
          check_field("bus_address", want.bus_address, out_tdata[31:0]);
          check_field("bus_data", want.bus_data, out_tdata[63:32]);
          check_field("result_status", ADDR_W'(want.result_status), ADDR_W'(out_tdata[65:64]));
          check_field("error_code", ADDR_W'(want.error_code), ADDR_W'(out_tdata[72:66]));
          check_field("failing_address", want.failing_address, out_tdata[104:73]);
          check_field("last", ADDR_W'(want.last), ADDR_W'(out_tlast));
        end
      end
    end
    pending = due_actions.size();
  end

endmodule

### tb/flash_erase_program_sequencer_tb.sv
// ----------------------------------------------------------------------------
// flash_erase_program_sequencer_tb
// Drives erase and program commands, status samples and ticks into the
// sequencer: a directed pass over the corner cases, then random command
// sequences and noise under several timeout settings, with bursty input and
// random output backpressure. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module flash_erase_program_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import feps_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int SETTINGS_RUN = 5;

  localparam logic [STAT_W-1:0] STAT_BUSY    = 18'h00001;
  localparam logic [STAT_W-1:0] STAT_EOP     = 18'h00002;
  localparam logic [STAT_W-1:0] STAT_WRP     = 18'h00100;
  localparam logic [STAT_W-1:0] STAT_ABORT   = 18'h20000;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 18'h0D0FC;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ACT_W-1:0]       out_tuser;
  logic                   out_tlast;

  int fail_count;
  int pending_results;
  int sent_items = 0;
  int burst_left = 0;
  int ready_eighths = 8;
  int mode_left = 0;

  always #5 clk = ~clk;

  flash_erase_program_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  flash_erase_program_sequencer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending_results)
  );

  // result backpressure: stretches of full rate and of varying stall density
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_eighths = ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(1, 7);
      mode_left     = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    out_tready <= ($urandom_range(0, 7) < ready_eighths);
  end

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                           input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] wdata,
                           input logic [STAT_W-1:0] st);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, st, wdata, cnt, addr};
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  // hold off until every expected transaction has come out
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [STAT_W-1:0] clean_status();
    return (STAT_W'($urandom) & STAT_IGNORED) | (($urandom_range(0, 1) != 0) ? STAT_EOP : '0);
  endfunction

  function automatic logic [STAT_W-1:0] fault_status();
    logic [STAT_W-1:0] flags;
    flags = STAT_W'($urandom) & ERR_MASK;
    if (flags == '0) flags = ERR_MASK;
    return clean_status() | flags;
  endfunction

  task automatic run_sequence();
    logic [REQ_W-1:0]  cmd;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] addr;
    int                pick;
    cmd  = ($urandom_range(0, 99) < 65) ? REQ_ERASE : REQ_PROG;
    pick = $urandom_range(0, 19);
    if (pick < 15) cnt = CNT_W'($urandom_range(0, 3));
    else if (pick < 18) cnt = CNT_W'($urandom_range(4, 2047));
    else cnt = ($urandom_range(0, 1) != 0) ? CNT_W'(MAX_PAGES) : '1;
    addr = $urandom;
    if ($urandom_range(0, 7) == 0) addr = ALL_ONES - ADDR_W'($urandom_range(0, 511));
    send_item(cmd, addr, cnt, $urandom, STAT_W'($urandom));
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)
        send_item(REQ_STATUS, $urandom, CNT_W'($urandom), $urandom, clean_status());
      else if (pick < 70)
        send_item(REQ_STATUS, $urandom, CNT_W'($urandom), $urandom,
                  STAT_W'($urandom) | STAT_BUSY);
      else if (pick < 84)
        send_item(REQ_TICK, $urandom, CNT_W'($urandom), $urandom, STAT_W'($urandom));
      else if (pick < 92)
        send_item(REQ_STATUS, $urandom, CNT_W'($urandom), $urandom, fault_status());
      else
        send_item(REQ_W'($urandom_range(0, 1)), $urandom, CNT_W'($urandom), $urandom,
                  STAT_W'($urandom));
    end
    // a flagged sample ends whatever is still running
    if ($urandom_range(0, 4) != 0)
      send_item(REQ_STATUS, $urandom, CNT_W'($urandom), $urandom, fault_status());
  endtask

  initial begin
    int target;
    int guard;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle: samples and ticks are dropped
    send_item(REQ_STATUS, '0, '0, '0, '0);
    send_item(REQ_TICK, '1, '1, '1, '1);
    // word program at the top of the address space
    send_item(REQ_PROG, '1, '0, '1, '0);
    send_item(REQ_STATUS, '0, '0, '0, STAT_EOP);
    send_item(REQ_STATUS, '0, '0, '0, '0);
    // zero pages
    send_item(REQ_ERASE, '0, '0, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, '0);
    // two pages from an unaligned start; busy, command while active, all flags
    send_item(REQ_ERASE, 32'h1234_5678, 11'd2, '0, '0);
    send_item(REQ_PROG, 32'h0000_0040, '0, 32'hA5A5_5A5A, '0);
    send_item(REQ_STATUS, '0, '0, '0, STAT_BUSY);
    send_item(REQ_TICK, '0, '0, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, STAT_EOP);
    send_item(REQ_STATUS, '0, '0, '0, ERR_MASK | STAT_EOP);
    // erase range whose end wraps
    send_item(REQ_ERASE, 32'hFFFF_FF80, 11'd2, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, '0);
    // count above the page limit; unclamped end would wrap
    send_item(REQ_ERASE, 32'hFFFB_FF80, '1, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, STAT_ABORT);
    // flag seen on the wait before programming
    send_item(REQ_PROG, 32'h0800_0000, '0, 32'h1234_ABCD, '0);
    send_item(REQ_STATUS, '0, '0, '0, STAT_WRP);
    // zero timeout: busy during a page erase
    set_register(CFG_TIMEOUT, '0);
    send_item(REQ_ERASE, 32'h0000_0100, 11'd1, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, '0);
    send_item(REQ_STATUS, '0, '0, '0, STAT_BUSY);
    // tick timeout on the wait before programming
    set_register(CFG_TIMEOUT, 16'd2);
    send_item(REQ_PROG, 32'h0000_0004, '0, '1, '0);
    repeat (3) send_item(REQ_TICK, '0, '0, '0, '0);

    for (int p = 0; p < SETTINGS_RUN; p++) begin
      case (p)
        0: set_register(CFG_TIMEOUT, CFG_W'($urandom_range(1, 6)));
        1: set_register(CFG_TIMEOUT, '0);
        2: set_register(CFG_TIMEOUT, '1);
        3: begin
          set_register(CFG_NO_TIMEOUT, 16'd1);
          set_register(CFG_TIMEOUT, CFG_W'($urandom));
        end
        default: begin
          set_register(CFG_NO_TIMEOUT, '0);
          set_register(CFG_TIMEOUT, CFG_W'($urandom_range(2, 12)));
        end
      endcase
      target = sent_items + RANDOM_ITEMS / SETTINGS_RUN;
      while (sent_items < target) begin
        if ($urandom_range(0, 3) != 0) run_sequence();
        else send_item(REQ_W'($urandom), $urandom, CNT_W'($urandom), $urandom,
                       STAT_W'($urandom));
        if ($urandom_range(0, 29) == 0) settle();
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_results != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
